@@ hdl/stage_dependency_scoreboard_top_assert.svh @@
// assertion macros for the stage dependency scoreboard
`ifndef STAGE_DEPENDENCY_SCOREBOARD_TOP_ASSERT_SVH
`define STAGE_DEPENDENCY_SCOREBOARD_TOP_ASSERT_SVH

// same-cycle implication, clocked on clk, off while arst_n is low
`define SDS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off while arst_n is low
`define SDS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/sds_pkg.sv @@
package sds_pkg;

	// fixed field widths
	localparam int MASK_W = 16;
	localparam int ID_W   = 4;
	localparam int REQ_W  = 2;
	localparam int DEG_W  = 8;
	localparam logic [DEG_W-1:0] DEG_MAX = {DEG_W{1'b1}};

	// request codes
	typedef enum logic [REQ_W-1:0] {
		REQ_CLEAR    = 2'd0,
		REQ_PHASE    = 2'd1,
		REQ_SEPARATE = 2'd2,
		REQ_BURN     = 2'd3
	} req_type_t;

	// per-lane operation
	typedef enum logic [1:0] {
		LOP_HOLD  = 2'd0,
		LOP_CLEAR = 2'd1,
		LOP_INC   = 2'd2,
		LOP_DEC   = 2'd3
	} lane_op_t;

	typedef struct packed {
		lane_op_t op;
		logic     sel;
	} lane_ctl_t;

	typedef struct packed {
		logic zero;
		logic sat;
	} lane_sts_t;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_READ = 4'b0010,
		ST_MOD  = 4'b0100,
		ST_FIN  = 4'b1000
	} seq_state_t;

	typedef enum logic {
		MODE_LOAD = 1'b0,
		MODE_DROP = 1'b1
	} seq_mode_t;

endpackage

@@ hdl/sds_if.sv @@
// request channel
interface sds_req_if import sds_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [REQ_W-1:0]  req_type;
	logic [MASK_W-1:0] phase_mask;
	logic [ID_W-1:0]   unit_id;
	logic [MASK_W-1:0] empty_mask;

	modport source (output valid, output req_type, output phase_mask, output unit_id,
		output empty_mask, input ready);
	modport sink (input valid, input req_type, input phase_mask, input unit_id,
		input empty_mask, output ready);
endinterface

// response channel
interface sds_rsp_if import sds_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [MASK_W-1:0] active_mask;
	logic [MASK_W-1:0] present_mask;
	logic              found;
	logic              overflow;

	modport source (output valid, output active_mask, output present_mask, output found,
		output overflow, input ready);
	modport sink (input valid, input active_mask, input present_mask, input found,
		input overflow, output ready);
endinterface

@@ hdl/sds_ram.sv @@
module sds_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ hdl/sds_lane.sv @@
module sds_lane import sds_pkg::*; #(
	parameter int COUNT_BITS = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lane_ctl_t             ctl,
	input  logic [COUNT_BITS-1:0] edge_in,
	output logic [COUNT_BITS-1:0] edge_out,
	output lane_sts_t             sts
);

	localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

	logic [DEG_W-1:0] indeg_q;
	logic [DEG_W-1:0] indeg_d;
	logic [DEG_W-1:0] edge_ext;
	logic             sat;

	assign edge_ext = DEG_W'(edge_in);

	// column update for this unit
	always_comb begin
		edge_out = edge_in;
		indeg_d  = indeg_q;
		sat      = 1'b0;
		if (ctl.sel) begin
			case (ctl.op)
				LOP_CLEAR: begin
					indeg_d = '0;
				end
				LOP_INC: begin
					if (edge_in == CNT_MAX || indeg_q == DEG_MAX) begin
						sat = 1'b1;
					end else begin
						edge_out = edge_in + 1'b1;
						indeg_d  = indeg_q + 1'b1;
					end
				end
				LOP_DEC: begin
					indeg_d = (indeg_q > edge_ext) ? indeg_q - edge_ext : '0;
				end
				default: begin
				end
			endcase
		end
	end

	// in-degree counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			indeg_q <= '0;
		end else begin
			indeg_q <= indeg_d;
		end
	end

	assign sts.zero = (indeg_q == '0);
	assign sts.sat  = sat;

endmodule

@@ hdl/stage_dependency_scoreboard_top.sv @@
// Stage dependency scoreboard. One result item per request item. The edge counts live in a
// single-port-read memory with one row per source unit; every row the request touches is
// read, then modified in all unit lanes at once (and written back for a phase load). The
// rows are those of the units that left between two phases for a phase load, or of the
// units removed for a separate or burnout check. After the last row the result is loaded
// into the output register once that is free, and the next item is accepted after that.
// Clear, the first phase and requests that touch no row go straight to the result. A new
// item is accepted while the previous result still waits on the response channel.
module stage_dependency_scoreboard_top import sds_pkg::*; #(
	parameter int MAX_STAGES = 16,
	parameter int COUNT_BITS = 4
) (
	input  logic     clk,
	input  logic     arst_n,
	sds_req_if.sink  req,
	sds_rsp_if.source rsp
);

	localparam int N     = MAX_STAGES;
	localparam int RW    = $clog2(N);
	localparam int EXT_W = (N > MASK_W) ? N : MASK_W;
	localparam int ROW_W = N * COUNT_BITS;

	seq_state_t       state_q;
	seq_mode_t        mode_q;
	logic [N-1:0]     pending_q;
	logic [N-1:0]     came_q;
	logic [RW-1:0]    row_q;
	logic [N-1:0]     present_q;
	logic [N-1:0]     prior_q;
	logic             first_q;
	logic             sat_q;
	logic [N-1:0]     valid_q;
	logic             found_q;
	logic             out_valid_q;
	logic [MASK_W-1:0] out_active_q;
	logic [MASK_W-1:0] out_present_q;
	logic             out_found_q;
	logic             out_overflow_q;

	req_type_t        rt;
	logic             accept;
	logic             out_load;
	logic [EXT_W-1:0] phase_ext;
	logic [EXT_W-1:0] empty_ext;
	logic [N-1:0]     cur_phase;
	logic [N-1:0]     cur_empty;
	logic [N-1:0]     gone;
	logic [N-1:0]     came;
	logic [N-1:0]     zero_vec;
	logic [N-1:0]     sat_vec;
	logic [N-1:0]     active_vec;
	logic [N-1:0]     sep_vec;
	logic [N-1:0]     drop_vec;
	logic [RW-1:0]    next_row;
	logic [N-1:0]     row_oh;
	logic [N-1:0]     pending_left;
	logic [ROW_W-1:0] rdata;
	logic [ROW_W-1:0] row_rd;
	logic [ROW_W-1:0] wdata;
	logic             we;
	logic             sat_any;
	lane_ctl_t        ctl [N];
	lane_sts_t        sts [N];
	logic [EXT_W-1:0] act_ext;
	logic [EXT_W-1:0] pres_ext;

	assign rt      = req_type_t'(req.req_type);
	assign req.ready = (state_q == ST_IDLE);
	assign accept  = req.valid && req.ready;

	// masks limited to the units that exist
	assign phase_ext = EXT_W'(req.phase_mask);
	assign empty_ext = EXT_W'(req.empty_mask);
	assign cur_phase = phase_ext[N-1:0];
	assign cur_empty = empty_ext[N-1:0];
	assign gone      = prior_q & ~cur_phase;
	assign came      = cur_phase & ~prior_q;

	// lane flags
	always_comb begin
		for (int i = 0; i < N; i++) begin
			zero_vec[i] = sts[i].zero;
			sat_vec[i]  = sts[i].sat;
			sep_vec[i]  = (int'(req.unit_id) == i) && present_q[i];
		end
	end

	assign active_vec = present_q & zero_vec;
	assign sat_any    = |sat_vec;
	assign drop_vec   = (rt == REQ_SEPARATE) ? sep_vec : (active_vec & cur_empty);

	// lowest pending row
	always_comb begin
		next_row = '0;
		for (int i = N - 1; i >= 0; i--) begin
			if (pending_q[i]) begin
				next_row = RW'(i);
			end
		end
	end

	assign row_oh       = N'(1) << row_q;
	assign pending_left = pending_q & ~row_oh;

	// edge count rows
	sds_ram #(
		.WIDTH (ROW_W),
		.DEPTH (N)
	) u_edge_ram (
		.clk   (clk),
		.we    (we),
		.waddr (row_q),
		.wdata (wdata),
		.raddr (next_row),
		.rdata (rdata)
	);

	assign we     = (state_q == ST_MOD) && (mode_q == MODE_LOAD);
	assign row_rd = valid_q[row_q] ? rdata : '0;

	// lane control
	always_comb begin
		for (int i = 0; i < N; i++) begin
			ctl[i].op  = LOP_HOLD;
			ctl[i].sel = 1'b0;
			if (accept) begin
				unique case (rt) inside
					REQ_CLEAR: begin
						ctl[i].op  = LOP_CLEAR;
						ctl[i].sel = 1'b1;
					end
					REQ_SEPARATE, REQ_BURN: begin
						ctl[i].op  = LOP_CLEAR;
						ctl[i].sel = drop_vec[i];
					end
					REQ_PHASE: begin
					end
				endcase
			end else if (state_q == ST_MOD) begin
				if (mode_q == MODE_LOAD) begin
					ctl[i].op  = LOP_INC;
					ctl[i].sel = came_q[i];
				end else begin
					ctl[i].op  = LOP_DEC;
					ctl[i].sel = present_q[i];
				end
			end
		end
	end

	// one lane per target unit
	for (genvar g = 0; g < N; g++) begin : g_lane
		sds_lane #(
			.COUNT_BITS (COUNT_BITS)
		) u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl[g]),
			.edge_in  (row_rd[g*COUNT_BITS +: COUNT_BITS]),
			.edge_out (wdata[g*COUNT_BITS +: COUNT_BITS]),
			.sts      (sts[g])
		);
	end

	assign out_load = (state_q == ST_FIN) && (!out_valid_q || rsp.ready);

	// sequencer and graph state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			mode_q    <= MODE_LOAD;
			pending_q <= '0;
			came_q    <= '0;
			row_q     <= '0;
			present_q <= '0;
			prior_q   <= '0;
			first_q   <= 1'b1;
			sat_q     <= 1'b0;
			valid_q   <= '0;
			found_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (rt) inside
							REQ_CLEAR: begin
								present_q <= '0;
								prior_q   <= '0;
								first_q   <= 1'b1;
								sat_q     <= 1'b0;
								valid_q   <= '0;
								found_q   <= 1'b0;
								state_q   <= ST_FIN;
							end
							REQ_PHASE: begin
								present_q <= present_q | cur_phase;
								prior_q   <= cur_phase;
								first_q   <= 1'b0;
								found_q   <= 1'b0;
								came_q    <= came;
								pending_q <= gone;
								mode_q    <= MODE_LOAD;
								state_q   <= (!first_q && gone != '0) ? ST_READ : ST_FIN;
							end
							REQ_SEPARATE, REQ_BURN: begin
								present_q <= present_q & ~drop_vec;
								pending_q <= drop_vec;
								mode_q    <= MODE_DROP;
								found_q   <= (rt == REQ_SEPARATE) && (drop_vec != '0);
								state_q   <= (drop_vec != '0) ? ST_READ : ST_FIN;
							end
						endcase
					end
				end
				ST_READ: begin
					row_q   <= next_row;
					state_q <= ST_MOD;
				end
				ST_MOD: begin
					pending_q[row_q] <= 1'b0;
					if (mode_q == MODE_LOAD) begin
						valid_q[row_q] <= 1'b1;
						sat_q          <= sat_q | sat_any;
					end else begin
						valid_q[row_q] <= 1'b0;
					end
					state_q <= (pending_left != '0) ? ST_READ : ST_FIN;
				end
				ST_FIN: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign act_ext  = EXT_W'(active_vec);
	assign pres_ext = EXT_W'(present_q);

	// output register payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_active_q   <= act_ext[MASK_W-1:0];
			out_present_q  <= pres_ext[MASK_W-1:0];
			out_found_q    <= found_q;
			out_overflow_q <= sat_q;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.active_mask  = out_active_q;
	assign rsp.present_mask = out_present_q;
	assign rsp.found        = out_found_q;
	assign rsp.overflow     = out_overflow_q;

	`include "stage_dependency_scoreboard_top_assert.svh"

	`SDS_ASSERT_IMP(a_mod_row_pending, state_q == ST_MOD, pending_q[row_q], "row under update is not pending")
	`SDS_ASSERT_IMP(a_read_has_work, state_q == ST_READ, pending_q != '0, "row read with nothing pending")
	`SDS_ASSERT_NXT(a_clear_empties, accept && rt == REQ_CLEAR, present_q == '0 && !sat_q && valid_q == '0, "clear left graph state")
	`SDS_ASSERT_IMP(a_result_from_fin, $rose(out_valid_q), $past(state_q) == ST_FIN, "result shown outside finish")

endmodule
